[sv/roulette_wheel_select_defines.svh]
// Assertion macros shared by the roulette wheel select RTL.
`ifndef ROULETTE_WHEEL_SELECT_DEFINES_SVH
`define ROULETTE_WHEEL_SELECT_DEFINES_SVH

`ifndef SYNTH
// Property checked on every clock edge outside reset.
`define RWS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rws assertion failed");
// Implication checked on every clock edge outside reset.
`define RWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rws implication failed");
// Consequence checked in the cycle after the antecedent.
`define RWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rws next-cycle check failed");
`else
`define RWS_ASSERT(lbl, prop)
`define RWS_ASSERT_IMP(lbl, ante, cons)
`define RWS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/rws_pkg.sv]
// Shared widths and parameter defaults for the roulette wheel select block.
package rws_pkg;

  localparam int unsigned OP_W        = 1;
  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned WEIGHT_IN_W = 16;
  localparam int unsigned TOTAL_W     = 22;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned COUNT_W     = 7;

  localparam int unsigned MAX_ENTRIES_DEF   = 64;
  localparam int unsigned WEIGHT_BITS_DEF   = 16;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [OP_W-1:0] OP_SELECT = 1'b1;

endpackage

[sv/rws_weight_mem.sv]
// Weight table: single write port, single registered read port.
module rws_weight_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/rws_scale.sv]
// Two-stage scaling: threshold = ceil(total * frac) and fallback index.
module rws_scale #(
  parameter int unsigned N_W           = 7,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rws_pkg::TOTAL_W-1:0]   total_i,
  input  logic [rws_pkg::FRAC_W-1:0]    frac_i,
  input  logic [rws_pkg::FRAC_W-1:0]    fallback_i,
  input  logic [N_W-1:0]                count_i,
  output logic                          valid_o,
  output logic [rws_pkg::TOTAL_W+rws_pkg::FRAC_W-FRACTION_BITS:0] thr_o,
  output logic [rws_pkg::INDEX_W-1:0]   fb_index_o
);
  import rws_pkg::*;

  localparam int unsigned PROD_W  = TOTAL_W + FRAC_W;
  localparam int unsigned THR_W   = PROD_W + 1 - FRACTION_BITS;
  localparam int unsigned FPROD_W = N_W + FRAC_W;
  localparam int unsigned FEXT_W  = (FPROD_W > FRACTION_BITS + INDEX_W) ?
                                    FPROD_W : FRACTION_BITS + INDEX_W;

  logic                 v1_q, v2_q;
  logic [PROD_W-1:0]    prod_q;
  logic [FPROD_W-1:0]   fprod_q;
  logic [PROD_W:0]      rounded;
  logic [FEXT_W-1:0]    fprod_ext;
  logic [THR_W-1:0]     thr_q;
  logic [INDEX_W-1:0]   fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  // round up: add all-ones below the binary point before the shift
  assign rounded   = {1'b0, prod_q} + {{(PROD_W + 1 - FRACTION_BITS){1'b0}},
                                       {FRACTION_BITS{1'b1}}};
  assign fprod_ext = FEXT_W'(fprod_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q  <= PROD_W'(total_i) * PROD_W'(frac_i);
      fprod_q <= FPROD_W'(count_i) * FPROD_W'(fallback_i);
    end
    if (v1_q) begin
      thr_q <= rounded[PROD_W:FRACTION_BITS];
      fb_q  <= fprod_ext[FRACTION_BITS+INDEX_W-1:FRACTION_BITS];
    end
  end

  assign valid_o    = v2_q;
  assign thr_o      = thr_q;
  assign fb_index_o = fb_q;

endmodule

[sv/roulette_wheel_select.sv]
// Roulette wheel select top level: command port, walk sequencer, weight table.
//
//  port group      dir   handshake             words
//  command         in    start / busy          operation, entry_index, weight, totals, fractions
//  result          out   done_o strobe         chosen_index
//  config          in    cfg_we_i              entries_in_use
//
// A write word is accepted while idle and busy stays low; the next word may follow at once.
// A select runs the scale stage and then the walk, which reads at most MAX_ENTRIES weights,
// one weight per cycle, from the single read port of the table.
// Reset clears the sequencer and entries_in_use; table contents are undefined until written.
// The result is a one-cycle strobe that cannot be stalled.
`include "roulette_wheel_select_defines.svh"

module roulette_wheel_select #(
  parameter int unsigned MAX_ENTRIES   = rws_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned WEIGHT_BITS   = rws_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned FRACTION_BITS = rws_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [rws_pkg::OP_W-1:0]        operation_i,
  input  logic [rws_pkg::INDEX_W-1:0]     entry_index_i,
  input  logic [rws_pkg::WEIGHT_IN_W-1:0] weight_value_i,
  input  logic [rws_pkg::TOTAL_W-1:0]     total_weight_i,
  input  logic [rws_pkg::FRAC_W-1:0]      random_fraction_i,
  input  logic [rws_pkg::FRAC_W-1:0]      fallback_fraction_i,
  input  logic                            cfg_we_i,
  input  logic [rws_pkg::COUNT_W-1:0]     cfg_wdata_i,
  output logic                            done_o,
  output logic [rws_pkg::INDEX_W-1:0]     chosen_index_o
);
  import rws_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);
  localparam int unsigned N_W    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned THR_W  = TOTAL_W + FRAC_W + 1 - FRACTION_BITS;
  localparam int unsigned SUM_W  = WEIGHT_BITS + N_W;
  localparam int unsigned CMP_W  = (THR_W > SUM_W) ? THR_W : SUM_W;
  localparam int unsigned IDX_W  = (N_W > INDEX_W) ? N_W : INDEX_W;
  localparam int unsigned NC_W   = (N_W > COUNT_W) ? N_W : COUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_WALK
  } state_e;

  state_e              state_q, state_d;
  logic [COUNT_W-1:0]  entries_q;
  logic [N_W-1:0]      count_q, count_d;
  logic [N_W-1:0]      idx_q, idx_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                pend_q, pend_d;
  logic                done_q, done_d;
  logic [INDEX_W-1:0]  chosen_q, chosen_d;

  logic                accept, wr_accept, sel_accept;
  logic [NC_W-1:0]     entries_ext;
  logic [N_W-1:0]      count_clamped;
  logic [IDX_W-1:0]    wr_idx_ext;
  logic                wr_en;
  logic                scale_valid;
  logic [THR_W-1:0]    thr;
  logic [INDEX_W-1:0]  fb_index;
  logic [WEIGHT_BITS-1:0] rdata;
  logic [SUM_W-1:0]    sum_eff;
  logic                cont, rd_en;
  logic [IDX_W-1:0]    last_idx;

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign wr_accept  = accept && (operation_i == OP_WRITE);
  assign sel_accept = accept && (operation_i == OP_SELECT);

  // entries_in_use saturates at the table depth
  assign entries_ext   = NC_W'(entries_q);
  assign count_clamped = (entries_ext > NC_W'(MAX_ENTRIES)) ? N_W'(MAX_ENTRIES)
                                                            : N_W'(entries_ext);

  assign wr_idx_ext = IDX_W'(entry_index_i);
  assign wr_en      = wr_accept && (wr_idx_ext < IDX_W'(MAX_ENTRIES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_we_i) begin
      entries_q <= cfg_wdata_i;
    end
  end

  rws_scale #(
    .N_W           (N_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sel_accept),
    .total_i    (total_weight_i),
    .frac_i     (random_fraction_i),
    .fallback_i (fallback_fraction_i),
    .count_i    (count_clamped),
    .valid_o    (scale_valid),
    .thr_o      (thr),
    .fb_index_o (fb_index)
  );

  // weight read last cycle is folded in before the compare
  assign sum_eff  = sum_q + (pend_q ? SUM_W'(rdata) : '0);
  assign cont     = (idx_q < count_q) && (CMP_W'(sum_eff) < CMP_W'(thr));
  assign rd_en    = (state_q == ST_WALK) && cont;
  assign last_idx = IDX_W'(idx_q - N_W'(1));

  rws_weight_mem #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (ADDR_W),
    .DATA_W (WEIGHT_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx_ext[ADDR_W-1:0]),
    .wdata_i (WEIGHT_BITS'(weight_value_i)),
    .re_i    (rd_en),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    pend_d   = pend_q;
    done_d   = 1'b0;
    chosen_d = chosen_q;
    case (state_q)
      ST_IDLE: begin
        if (sel_accept) begin
          count_d = count_clamped;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (scale_valid) begin
          idx_d   = '0;
          sum_d   = '0;
          pend_d  = 1'b0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        sum_d = sum_eff;
        if (cont) begin
          idx_d  = idx_q + N_W'(1);
          pend_d = 1'b1;
        end else begin
          pend_d   = 1'b0;
          done_d   = 1'b1;
          chosen_d = (idx_q == '0) ? fb_index : last_idx[INDEX_W-1:0];
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      sum_q    <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      chosen_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
      chosen_q <= chosen_d;
    end
  end

  assign done_o         = done_q;
  assign chosen_index_o = chosen_q;

  `RWS_ASSERT_IMP(a_done_idle, done_o, !busy)
  `RWS_ASSERT_IMP(a_done_after_busy, done_o, $past(busy))
  `RWS_ASSERT_NEXT(a_select_busy, sel_accept, busy)
  `RWS_ASSERT_IMP(a_idx_bound, state_q == ST_WALK, idx_q <= count_q)
  `RWS_ASSERT_IMP(a_no_write_busy, wr_en, !busy)

endmodule
